// ===== src/gb5_pkg.sv =====
`default_nettype none

package gb5_pkg;

  // line buffer depth and its address width
  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // field and register widths
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int COL_W     = 12;
  localparam int ROW_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;
  localparam int HEIGHT_LIMIT = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // four stored rows per column, oldest in the lowest lane
  localparam int LANES  = 4;
  localparam int LINE_W = LANES * PIX_W;

  // kernel, sum 273
  localparam int KW = 6;
  localparam logic [KW-1:0] KERNEL [5][5] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  // row sum max 255*107, total max 255*273
  localparam int RSUM_W = 15;
  localparam int ACC_W  = 17;

  // floor(n/273) = (n * RECIP) >> RECIP_SHIFT, exact for n <= 255*273
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 31;
  localparam logic [RECIP_W-1:0] RECIP = 23'd7866241;
  localparam int PROD_W = ACC_W + RECIP_W;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

// ===== src/gaussian_blur_5x5_rgb_top.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: red, green, blue (8 bits each)
// m_axis    out        m_axis_tvalid/tready       tdata: red, green, blue; tlast: frame end
// cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// One grid position per clock while m_axis is not stalled and the RAM sweep is done;
// a result passes the line-buffer read, window, row sums, total and divide registers.
// Line buffer: one RAM of MAX_WIDTH columns holding the four previous rows; a
// column is read at accept and, if in the image, written back as the word leaves stage 1.
// After reset a sweep zeroes all MAX_WIDTH (2048) entries with s_axis_tready low.
// A stall on m_axis freezes every stage and drops s_axis_tready.

module gaussian_blur_5x5_rgb_top
  import gb5_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [PIX_W-1:0]          m_axis_tdata,   // blurred_red, blurred_green, blurred_blue
  output logic                      m_axis_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  // configuration
  logic [COL_W-1:0] image_width;
  logic [ROW_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= COL_W'(640);
      image_height <= ROW_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[COL_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero counts as one, saturate at the limits
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = COL_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(image_height) > HEIGHT_LIMIT) begin
      h_eff = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = image_height;
    end
  end

  // handshake: every stage moves together whenever the output slot can advance
  logic adv;
  logic clr_busy;
  logic accept;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !clr_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // grid position of the next word
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W:0]   w_plus1;
  logic [ROW_W:0]   h_plus1;
  logic             col_ok;
  logic             in_img;
  logic             at_row_end;

  assign w_plus1    = {1'b0, w_eff} + 1'b1;
  assign h_plus1    = {1'b0, h_eff} + 1'b1;
  assign col_ok     = column_count < w_eff;
  assign in_img     = col_ok && (row_count < h_eff);
  assign at_row_end = {1'b0, column_count} >= w_plus1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (at_row_end) begin
        column_count <= '0;
        row_count    <= ({1'b0, row_count} >= h_plus1) ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // line buffer RAM: lane 0 is row r-4, lane 3 is row r-1
  logic [LINE_W-1:0] row_mem [MAX_WIDTH];
  logic [LINE_W-1:0] mem_rdata;
  logic [LINE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] clr_addr;

  assign mem_raddr = ADDR_W'(column_count);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata <= row_mem[mem_raddr];
    end
  end

  // zero the RAM once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MAX_WIDTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // stage 1: word waits for its column read
  logic              s1_valid;
  logic              s1_col_ok;
  logic [3:0]        s1_rge;      // bit i: row >= i+1
  pixel_t            s1_cur;
  logic [ADDR_W-1:0] s1_addr;
  tag_t              s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_ok <= col_ok;
      for (int i = 0; i < 4; i++) begin
        s1_rge[i] <= 32'(row_count) >= i + 1;
      end
      s1_cur      <= in_img ? s_axis_tdata : '0;
      s1_addr     <= mem_raddr;
      s1_tag.emit <= (column_count >= COL_W'(2)) && (row_count >= ROW_W'(2)) &&
                     ({1'b0, column_count} <= w_plus1) && ({1'b0, row_count} <= h_plus1);
      s1_tag.last <= ({1'b0, column_count} == w_plus1) && ({1'b0, row_count} == h_plus1);
    end
  end

  // gate lanes of rows above the frame, then shift the column and write it back
  pixel_t col_in [5];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      col_in[k] = (s1_col_ok && s1_rge[3-k]) ? mem_rdata[k*PIX_W +: PIX_W] : '0;
    end
    col_in[4] = s1_cur;
  end

  assign mem_we    = clr_busy || (adv && s1_valid && s1_col_ok);
  assign mem_waddr = clr_busy ? clr_addr : s1_addr;
  assign mem_wdata = clr_busy ? '0 : {s1_cur, mem_rdata[LINE_W-1:PIX_W]};

  // stage 2: window, column 4 newest
  pixel_t win [5][5];
  logic   s2_valid;
  tag_t   s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (adv) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 4; j++) begin
            win[i][j] <= win[i][j+1];
          end
          win[i][4] <= col_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_tag <= s1_tag;
    end
  end

  // stage 3: weighted row sums per channel
  logic [RSUM_W-1:0] rsum_comb [3][5];
  logic [RSUM_W-1:0] s3_rsum   [3][5];
  logic              s3_valid;
  tag_t              s3_tag;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 5; i++) begin
        rsum_comb[ch][i] = '0;
        for (int j = 0; j < 5; j++) begin
          rsum_comb[ch][i] = rsum_comb[ch][i] +
            RSUM_W'(win[i][j][ch*CHAN_W +: CHAN_W]) * RSUM_W'(KERNEL[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rsum <= rsum_comb;
      s3_tag  <= s2_tag;
    end
  end

  // stage 4: full weighted sum per channel
  logic [ACC_W-1:0] acc_comb [3];
  logic [ACC_W-1:0] s4_acc   [3];
  logic             s4_valid;
  tag_t             s4_tag;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc_comb[ch] = '0;
      for (int i = 0; i < 5; i++) begin
        acc_comb[ch] = acc_comb[ch] + ACC_W'(s3_rsum[ch][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_acc <= acc_comb;
      s4_tag <= s3_tag;
    end
  end

  // stage 5: divide by 273 as a reciprocal multiply; this is the output slot
  logic [PROD_W-1:0] s5_prod [3];
  logic              s5_valid;
  tag_t              s5_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        s5_prod[ch] <= PROD_W'(s4_acc[ch]) * PROD_W'(RECIP);
      end
      s5_tag <= s4_tag;
    end
  end

  assign m_axis_tvalid = s5_valid && s5_tag.emit;
  assign m_axis_tlast  = s5_tag.last;
  assign m_axis_tdata  = {s5_prod[2][RECIP_SHIFT +: CHAN_W],
                          s5_prod[1][RECIP_SHIFT +: CHAN_W],
                          s5_prod[0][RECIP_SHIFT +: CHAN_W]};

endmodule

`default_nettype wire

// ===== src/gb5_checker.sv =====
`default_nettype none

module gb5_checker
  import gb5_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [PIX_W-1:0]     m_axis_tdata,
  input wire logic                 m_axis_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // a stall on the output freezes the input side
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted during output stall");

  // line buffer sweep keeps the input closed right after reset
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input open during line buffer clear");

  // reset empties the pipeline
  a_out_empty_after_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word present after reset");

endmodule

bind gaussian_blur_5x5_rgb_top gb5_checker u_gb5_checker (.*);

`default_nettype wire

// ===== tb/sv/gaussian_blur_5x5_rgb_top_tb.sv =====
`timescale 1ns / 100ps

module gaussian_blur_5x5_rgb_top_tb
  import gb5_pkg::*;
();

  localparam int LATENCY = 5;
  // Let a word that makes no result clear the pipe before a size write.
  localparam int SETTLE_CYCLES = LATENCY + 4;
  localparam int END_CYCLES = 4 * LATENCY;
  localparam int EXTREME_WORDS = 120;
  localparam int RANDOM_WORDS = 520;
  // Long output stall: starts after this many results, once the sender is
  // offering, and lasts this many cycles.
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES = 400;
  // Covers the line buffer clear after reset and the long stall.
  localparam int WATCHDOG_LIMIT = 8 * MAX_WIDTH;
  localparam int MAX_REPORTS = 40;
  // Sits above the 12-bit width register; the block must drop it.
  localparam logic [CFG_DAT_W-1:0] WIDTH_JUNK_BIT = 13'h1000;

  typedef struct packed {
    pixel_t rgb;
    logic   frame_end;
  } blur_word_t;

  // Mirror of the blur: size registers, four stored rows, 5x5 window and the grid
  // position, plus the queue of blurred words still owed by the block.
  class blur_scoreboard;
    localparam int unsigned KERNEL_TOTAL = 273;

    int unsigned weight [5][5];
    string chan_name [3] = '{"red", "green", "blue"};
    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    pixel_t line_mem [LANES][MAX_WIDTH];
    pixel_t window_px [5][5];
    int unsigned col_pos;
    int unsigned row_pos;
    blur_word_t blurred_q [$];
    string complaints [$];
    int unsigned results_checked;
    int unsigned frame_ends;

    function new();
      weight = '{'{1, 4, 7, 4, 1}, '{4, 16, 26, 16, 4}, '{7, 26, 41, 26, 7},
                 '{4, 16, 26, 16, 4}, '{1, 4, 7, 4, 1}};
      width_reg = COL_W'(640);
      height_reg = ROW_W'(480);
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (window_px[i, j]) window_px[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      results_checked = 0;
      frame_ends = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = value[COL_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = value[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return blurred_q.size();
    endfunction

    function bit at_frame_start();
      return col_pos == 0 && row_pos == 0;
    endfunction

    function void note_input(pixel_t px);
      int unsigned w, h, c, r, acc;
      bit col_ok;
      pixel_t column [5];
      blur_word_t res;
      // zero sizes act as one, oversize saturates
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
      c = col_pos;
      r = row_pos;
      col_ok = c < w;
      // padding columns and rows feed zero; rows above the image read zero
      column[4] = (col_ok && r < h) ? px : '0;
      for (int i = 1; i <= 4; i++)
        column[4-i] = (col_ok && r >= i) ? line_mem[4-i][c] : '0;
      if (col_ok) begin
        for (int k = 0; k < 3; k++) line_mem[k][c] = line_mem[k+1][c];
        line_mem[3][c] = column[4];
      end
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) window_px[i][j] = window_px[i][j+1];
        window_px[i][4] = column[i];
      end
      if (c >= 2 && r >= 2 && c <= w + 1 && r <= h + 1) begin
        for (int ch = 0; ch < 3; ch++) begin
          acc = 0;
          for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
              acc += window_px[i][j][ch*CHAN_W +: CHAN_W] * weight[i][j];
          res.rgb[ch*CHAN_W +: CHAN_W] = CHAN_W'(acc / KERNEL_TOTAL);
        end
        res.frame_end = (c == w + 1 && r == h + 1);
        blurred_q.push_back(res);
      end
      // a position past the grid, left over from a bigger size, wraps at once
      if (c >= w + 1) begin
        col_pos = 0;
        row_pos = (r >= h + 1) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_result(blur_word_t got);
      blur_word_t want;
      results_checked++;
      if (blurred_q.size() == 0) begin
        complaints.push_back($sformatf("blurred word %0d arrived with nothing owed",
                                       results_checked));
        return;
      end
      want = blurred_q.pop_front();
      for (int ch = 0; ch < 3; ch++) begin
        if (got.rgb[ch*CHAN_W +: CHAN_W] !== want.rgb[ch*CHAN_W +: CHAN_W])
          complaints.push_back($sformatf("blurred word %0d %s: got %0d, want %0d",
                                         results_checked, chan_name[ch],
                                         got.rgb[ch*CHAN_W +: CHAN_W],
                                         want.rgb[ch*CHAN_W +: CHAN_W]));
      end
      if (got.frame_end !== want.frame_end)
        complaints.push_back($sformatf("blurred word %0d frame end: got %b, want %b",
                                       results_checked, got.frame_end, want.frame_end));
      if (want.frame_end) frame_ends++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  pixel_t s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  pixel_t m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  blur_scoreboard blur_sb;
  int unsigned words_in = 0;
  int unsigned mismatches = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;
  bit src_burst = 1'b0;
  bit snk_burst = 1'b0;
  bit hold_done = 1'b0;

  gaussian_blur_5x5_rgb_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // pixel_red, pixel_green, pixel_blue
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // blurred_red, blurred_green, blurred_blue
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("  mismatch: %s", what);
  endtask

  // Random gap before the next word; now and then flip into or out of
  // a burst where no gaps are taken at all.
  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 47) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 3);
  endfunction

  // Mostly random colors, with flat black and flat white mixed in so the
  // full-scale sums and the top result of 255 come up often.
  function automatic pixel_t draw_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until taken. Keep tvalid high across
  // back-to-back words rather than dropping it for a cycle.
  task automatic send_word(pixel_t px);
    int unsigned gap;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    blur_sb.note_input(px);
    words_in++;
  endtask

  // Drop tvalid, wait for every owed result, then let the pipe settle so a
  // size write lands on an idle block.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (blur_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers on back-to-back edges; keep cfg_we high between.
  task automatic write_size(logic [CFG_DAT_W-1:0] w, logic [CFG_DAT_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    blur_sb.set_register(REG_IMAGE_WIDTH, w);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    blur_sb.set_register(REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // New size, then whole frames (finishing any frame left open), then a run
  // of loose words that leaves the next size write landing mid-frame.
  task automatic run_phase(logic [CFG_DAT_W-1:0] w, logic [CFG_DAT_W-1:0] h,
                           int unsigned frames, int unsigned words);
    quiesce();
    write_size(w, h);
    repeat (frames) begin
      do send_word(draw_pixel()); while (!blur_sb.at_frame_start());
    end
    repeat (words) send_word(draw_pixel());
  endtask

  // Receiver: random gaps and bursts; once enough results have passed and the
  // sender is offering, refuse output for a long stretch so the block backs up
  // and drops s_axis_tready.
  initial begin
    blur_word_t got;
    int unsigned gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = draw_gap(snk_burst);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got.rgb = m_axis_tdata;
      got.frame_end = m_axis_tlast;
      blur_sb.check_result(got);
      while (blur_sb.complaints.size() != 0) report(blur_sb.complaints.pop_front());
      if (!hold_done && blur_sb.results_checked >= HOLD_AT_RESULT && s_axis_tvalid) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results owed",
               WATCHDOG_LIMIT, blur_sb.pending());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pixel_t corner_px [4];
    logic [CFG_DAT_W-1:0] w, h;
    int unsigned random_start;
    corner_px = '{24'hFFFFFF, 24'h000000, 24'hAA55AA, 24'h55AA55};
    blur_sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // 2x2 image: full-scale, zero and alternating-bit pixels in the corners;
    // padding positions carry all ones, which must be ignored. The size write
    // lands during the line buffer clear after reset.
    quiesce();
    write_size(CFG_DAT_W'(2), CFG_DAT_W'(2));
    for (int k = 0; k < 16; k++)
      send_word((k % 4 < 2 && k / 4 < 2) ? corner_px[(k / 4) * 2 + k % 4] : '1);

    // Zero width (with junk above the register) and zero height act as 1x1.
    quiesce();
    write_size(WIDTH_JUNK_BIT, '0);
    for (int k = 0; k < 9; k++) send_word((k == 0) ? '1 : draw_pixel());

    // Extremes as partial frames: oversize width saturating to the line buffer
    // depth, oversize height saturating to the row limit, then the exact
    // maxima; each run breaks off so the next size write lands mid-frame.
    run_phase(13'h0FFF, CFG_DAT_W'(1), 0, EXTREME_WORDS);
    run_phase(CFG_DAT_W'(1), 13'h1FFF, 0, EXTREME_WORDS);
    run_phase(CFG_DAT_W'(MAX_WIDTH), CFG_DAT_W'(HEIGHT_LIMIT), 0, EXTREME_WORDS);

    // Random sizes: mostly whole frames, some short runs that break off so
    // the next size write shrinks the grid under the position counters.
    random_start = words_in;
    while (words_in - random_start < RANDOM_WORDS) begin
      w = ($urandom_range(0, 9) == 0) ? CFG_DAT_W'($urandom_range(9, 24)) :
                                        CFG_DAT_W'($urandom_range(1, 8));
      h = CFG_DAT_W'($urandom_range(1, 6));
      if ($urandom_range(0, 15) == 0) w = '0;
      if ($urandom_range(0, 15) == 0) h = '0;
      if ($urandom_range(0, 7) == 0) w |= WIDTH_JUNK_BIT;
      if ($urandom_range(0, 4) == 0) run_phase(w, h, 0, $urandom_range(1, 30));
      else run_phase(w, h, $urandom_range(1, 2), 0);
    end

    // Drain and give a late stray word time to show up.
    s_axis_tvalid <= 1'b0;
    while (blur_sb.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d pixel words over %0d image sizes, 1x1 up to the largest sizes.",
             words_in, settings_run);
    $display("Checked %0d blurred words, %0d frame ends, one long stall; %0d mismatches.",
             blur_sb.results_checked, blur_sb.frame_ends, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
